// ----- rtl/gfd_pkg.sv -----
// Shared constants and types of the gain and feedback delay block.
`timescale 1ns / 1ps
package gfd_pkg;

   // Default sizes of the delay store
   localparam int DELAY_FRAMES_MAX_DEF = 16384;
   localparam int DELAY_CHANNELS_DEF   = 2;

   // Channels at or above this are muted
   localparam int MAX_CHANNELS = 8;

   localparam int SAMPLE_W  = 32;
   localparam int CH_W      = 3;
   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 14;
   localparam int LEN_W     = 15;

   // Configuration port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [63:0]       GAINS_RESET    = 64'h4000_4000_4000_4000;
   localparam logic [GAIN_W-1:0] FEEDBACK_RESET = 16'd5734;
   localparam logic [GAIN_W-1:0] MIX_RESET      = 16'd4096;

   // Audio limits
   localparam logic signed [SAMPLE_W-1:0] AUD_MAX = 32'sh7FFF_FF00;
   localparam logic signed [SAMPLE_W-1:0] AUD_MIN = 32'sh8000_0000;

   // Result queue between the pipeline and the output channel
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int INFLIGHT_W = 2;

   typedef struct packed {
      logic [63:0]       gains_low;
      logic [63:0]       gains_high;
      logic              delay_enable;
      logic [LEN_W-1:0]  delay_length;
      logic [GAIN_W-1:0] feedback_gain;
      logic [GAIN_W-1:0] mix_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       eof;
   } rsp_item_type;

   typedef struct packed {
      logic                  clearing;
      logic [INFLIGHT_W-1:0] in_flight;
   } pipe_status_type;

endpackage

// ----- rtl/gfd_stream_if.sv -----
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps
interface gfd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gfd_pkg::SAMPLE_W-1:0] sample_in;
   logic [gfd_pkg::CH_W-1:0]            channel;
   logic                                end_of_frame;

   modport source (output valid, output sample_in, output channel, output end_of_frame,
                   input ready);
   modport sink (input valid, input sample_in, input channel, input end_of_frame,
                 output ready);
endinterface

interface gfd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gfd_pkg::SAMPLE_W-1:0] sample_out;
   logic                                end_of_frame_out;

   modport source (output valid, output sample_out, output end_of_frame_out, input ready);
   modport sink (input valid, input sample_out, input end_of_frame_out, output ready);
endinterface

// ----- rtl/gfd_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/gfd_csr.sv -----
// APB-style configuration registers.
`timescale 1ns / 1ps
module gfd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gfd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [gfd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [gfd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output gfd_pkg::cfg_type                cfg,
   output logic                            length_written
);

   localparam logic [2:0] REG_GAINS_LOW  = 3'd0;
   localparam logic [2:0] REG_GAINS_HIGH = 3'd1;
   localparam logic [2:0] REG_ENABLE     = 3'd2;
   localparam logic [2:0] REG_LENGTH     = 3'd3;
   localparam logic [2:0] REG_FEEDBACK   = 3'd4;
   localparam logic [2:0] REG_MIX        = 3'd5;

   gfd_pkg::cfg_type cfg_ff;
   gfd_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             wr;

   assign index  = paddr[5:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in         = cfg_ff;
      length_written = 1'b0;
      if (wr) begin
         unique case (index)
            REG_GAINS_LOW:  cfg_in.gains_low  = pwdata;
            REG_GAINS_HIGH: cfg_in.gains_high = pwdata;
            REG_ENABLE:     cfg_in.delay_enable = pwdata[0];
            REG_LENGTH: begin
               cfg_in.delay_length = pwdata[gfd_pkg::LEN_W-1:0];
               length_written      = 1'b1;
            end
            REG_FEEDBACK:   cfg_in.feedback_gain = pwdata[gfd_pkg::GAIN_W-1:0];
            REG_MIX:        cfg_in.mix_gain      = pwdata[gfd_pkg::GAIN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gains_low     <= gfd_pkg::GAINS_RESET;
         cfg_ff.gains_high    <= gfd_pkg::GAINS_RESET;
         cfg_ff.delay_enable  <= 1'b0;
         cfg_ff.delay_length  <= '0;
         cfg_ff.feedback_gain <= gfd_pkg::FEEDBACK_RESET;
         cfg_ff.mix_gain      <= gfd_pkg::MIX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_GAINS_LOW:  prdata = cfg_ff.gains_low;
         REG_GAINS_HIGH: prdata = cfg_ff.gains_high;
         REG_ENABLE:     prdata = gfd_pkg::CSR_DATA_W'(cfg_ff.delay_enable);
         REG_LENGTH:     prdata = gfd_pkg::CSR_DATA_W'(cfg_ff.delay_length);
         REG_FEEDBACK:   prdata = gfd_pkg::CSR_DATA_W'(cfg_ff.feedback_gain);
         REG_MIX:        prdata = gfd_pkg::CSR_DATA_W'(cfg_ff.mix_gain);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/gfd_pipe.sv -----
// Gain, delay store read-modify-write pipeline and store clearing pass.
`timescale 1ns / 1ps
module gfd_pipe #(
   parameter int DELAY_FRAMES_MAX = gfd_pkg::DELAY_FRAMES_MAX_DEF,
   parameter int DELAY_CHANNELS   = gfd_pkg::DELAY_CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gfd_pkg::cfg_type                    cfg,
   input  logic                                length_written,
   input  logic                                req_valid,
   input  logic signed [gfd_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [gfd_pkg::CH_W-1:0]            req_channel,
   input  logic                                req_end_of_frame,
   output logic                                req_ready,
   input  logic [gfd_pkg::FIFO_CNT_W-1:0]      fifo_count,
   output logic                                push,
   output gfd_pkg::rsp_item_type               push_item,
   output gfd_pkg::pipe_status_type            status
);

   localparam int SW          = gfd_pkg::SAMPLE_W;
   localparam int GW          = gfd_pkg::GAIN_W;
   localparam int PROD_W      = SW + GW;
   localparam int MAG_W       = PROD_W - gfd_pkg::GAIN_FRAC;
   localparam int SUM_W       = MAG_W + 2;
   localparam int STORE_WORDS = DELAY_FRAMES_MAX * DELAY_CHANNELS;
   localparam int ADDR_W      = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;
   localparam int POS_W       = DELAY_FRAMES_MAX > 1 ? $clog2(DELAY_FRAMES_MAX) : 1;
   localparam int CMP_W       = (POS_W > gfd_pkg::LEN_W ? POS_W : gfd_pkg::LEN_W) + 1;
   localparam int CHX_W       = gfd_pkg::CH_W + 1;
   localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(STORE_WORDS - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(gfd_pkg::AUD_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(gfd_pkg::AUD_MIN);

   function automatic logic signed [SUM_W-1:0] signed_mag(input logic neg,
                                                          input logic [MAG_W-1:0] mag);
      logic signed [SUM_W-1:0] m;
      m = $signed({{(SUM_W - MAG_W){1'b0}}, mag});
      return neg ? -m : m;
   endfunction

   function automatic logic signed [SW-1:0] sat_audio(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[SW-1:0];
   endfunction

   // Clearing pass
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Frame position
   logic [POS_W-1:0]  pos_ff, pos_in;

   // Front end
   logic [CMP_W-1:0]    len_ext, eff_len, pos_next;
   logic [POS_W-1:0]    pos_sel;
   logic                active, in_range, is_delay, hazard, credit_ok, accept;
   logic [CHX_W-1:0]    ch_ext;
   logic [63:0]         bank;
   logic [GW-1:0]       gain;
   logic [SW-1:0]       x_u, x_mag;
   logic [ADDR_W-1:0]   addr;

   // Stage 1
   logic                v1_ff, echo1_ff, mute1_ff, eof1_ff, neg1_ff;
   logic [ADDR_W-1:0]   addr1_ff;
   logic [PROD_W-1:0]   prod1_ff;
   logic [SW-1:0]       rdata, d_mag;
   logic signed [SW-1:0] s1;

   // Stage 2
   logic                v2_ff, echo2_ff, eof2_ff, dneg2_ff;
   logic [ADDR_W-1:0]   addr2_ff;
   logic signed [SW-1:0] s2_ff;
   logic [SW-1:0]       dmag2_ff;

   // Stage 3
   logic                v3_ff, echo3_ff, eof3_ff, dneg3_ff;
   logic [ADDR_W-1:0]   addr3_ff;
   logic signed [SW-1:0] s3_ff, out3, wb3;
   logic [PROD_W-1:0]   pm3_ff, pf3_ff;
   logic signed [SUM_W-1:0] s3_ext;

   localparam int INFLIGHT_W_L = gfd_pkg::INFLIGHT_W;
   logic [INFLIGHT_W_L-1:0] in_flight;

   // RAM port
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [SW-1:0]     ram_wdata;

   // ---------------- front end ----------------
   assign len_ext  = CMP_W'(cfg.delay_length);
   assign eff_len  = (len_ext > CMP_W'(DELAY_FRAMES_MAX)) ? CMP_W'(DELAY_FRAMES_MAX) : len_ext;
   assign active   = cfg.delay_enable && (eff_len != '0);
   assign pos_sel  = (CMP_W'(pos_ff) < eff_len) ? pos_ff : '0;
   assign ch_ext   = {1'b0, req_channel};
   assign in_range = ch_ext < CHX_W'(gfd_pkg::MAX_CHANNELS);
   assign is_delay = active && in_range && (ch_ext < CHX_W'(DELAY_CHANNELS));
   assign addr     = ADDR_W'(pos_sel) * ADDR_W'(DELAY_CHANNELS) + ADDR_W'(req_channel);

   // Hold a beat whose store word is still being rewritten further down
   assign hazard = is_delay && ((v1_ff && echo1_ff && addr1_ff == addr) ||
                                (v2_ff && echo2_ff && addr2_ff == addr) ||
                                (v3_ff && echo3_ff && addr3_ff == addr));

   assign in_flight = INFLIGHT_W_L'(v1_ff) + INFLIGHT_W_L'(v2_ff) + INFLIGHT_W_L'(v3_ff);
   assign credit_ok = ({1'b0, fifo_count} + (gfd_pkg::FIFO_CNT_W + 1)'(in_flight))
                      < (gfd_pkg::FIFO_CNT_W + 1)'(gfd_pkg::FIFO_DEPTH);

   assign req_ready = !clr_ff && credit_ok && !hazard;
   assign accept    = req_valid && req_ready;

   assign bank  = req_channel[2] ? cfg.gains_high : cfg.gains_low;
   assign gain  = bank[{req_channel[1:0], 4'b0000} +: GW];
   assign x_u   = req_sample_in;
   assign x_mag = x_u[SW-1] ? (~x_u + 1'b1) : x_u;

   assign pos_next = CMP_W'(pos_ff) + 1'b1;

   always_comb begin
      pos_in = pos_ff;
      if (length_written) begin
         pos_in = '0;
      end else if (accept && req_end_of_frame && active) begin
         pos_in = (pos_next >= eff_len) ? '0 : pos_next[POS_W-1:0];
      end
   end

   // Clear the store word by word after reset, from address zero to the last word
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         pos_ff      <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         pos_ff      <= pos_in;
         v1_ff       <= accept;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
      end
   end

   // ---------------- stage 1: store word arrives, saturate scaled sample ----------------
   always_ff @(posedge clock) begin
      echo1_ff <= is_delay;
      mute1_ff <= !in_range;
      eof1_ff  <= req_end_of_frame;
      neg1_ff  <= x_u[SW-1];
      addr1_ff <= addr;
      prod1_ff <= PROD_W'(x_mag) * PROD_W'(gain);
   end

   assign d_mag = rdata[SW-1] ? (~rdata + 1'b1) : rdata;
   assign s1    = mute1_ff ? '0
                  : sat_audio(signed_mag(neg1_ff, prod1_ff[PROD_W-1:gfd_pkg::GAIN_FRAC]));

   // ---------------- stage 2: register delayed word magnitude and sign ----------------
   always_ff @(posedge clock) begin
      echo2_ff <= echo1_ff;
      eof2_ff  <= eof1_ff;
      addr2_ff <= addr1_ff;
      s2_ff    <= s1;
      dneg2_ff <= rdata[SW-1];
      dmag2_ff <= d_mag;
   end

   // ---------------- stage 3: delayed word times mix and feedback, sum, saturate, write back ----------------
   always_ff @(posedge clock) begin
      echo3_ff <= echo2_ff;
      eof3_ff  <= eof2_ff;
      addr3_ff <= addr2_ff;
      s3_ff    <= s2_ff;
      dneg3_ff <= dneg2_ff;
      pm3_ff   <= PROD_W'(dmag2_ff) * PROD_W'(cfg.mix_gain);
      pf3_ff   <= PROD_W'(dmag2_ff) * PROD_W'(cfg.feedback_gain);
   end

   assign s3_ext = SUM_W'(s3_ff);
   assign out3   = echo3_ff
                   ? sat_audio(s3_ext + signed_mag(dneg3_ff, pm3_ff[PROD_W-1:gfd_pkg::GAIN_FRAC]))
                   : s3_ff;
   assign wb3    = sat_audio(s3_ext + signed_mag(dneg3_ff, pf3_ff[PROD_W-1:gfd_pkg::GAIN_FRAC]));

   assign push             = v3_ff;
   assign push_item.sample = out3;
   assign push_item.eof    = eof3_ff;

   assign ram_we    = clr_ff || (v3_ff && echo3_ff);
   assign ram_waddr = clr_ff ? clr_addr_ff : addr3_ff;
   assign ram_wdata = clr_ff ? '0 : wb3;

   gfd_ram #(
      .WIDTH (SW),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept && is_delay),
      .raddr (addr),
      .rdata (rdata)
   );

   assign status.clearing  = clr_ff;
   assign status.in_flight = in_flight;

endmodule

// ----- rtl/gfd_out_fifo.sv -----
// Result queue that decouples the pipeline from the response channel.
`timescale 1ns / 1ps
module gfd_out_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  gfd_pkg::rsp_item_type          push_item,
   input  logic                           pop,
   output logic                           valid,
   output gfd_pkg::rsp_item_type          head,
   output logic [gfd_pkg::FIFO_CNT_W-1:0] count
);

   gfd_pkg::rsp_item_type                 slot_ff [gfd_pkg::FIFO_DEPTH];
   logic [gfd_pkg::FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [gfd_pkg::FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [gfd_pkg::FIFO_CNT_W-1:0]        count_ff, count_in;
   logic                                  do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign valid = count_ff != '0;
   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ----- rtl/gain_and_feedback_delay.sv -----
// Top level of the per-channel gain and feedback delay (echo) block.
//
// Request beats carry one signed 32-bit sample, its channel number and an
// end-of-frame flag; response beats carry the processed sample and the flag,
// in request order. Registers are written over the APB-style port; write
// them only while no beat is in flight, as the block does not enforce it.
// An accepted request passes through pipeline stages 1 to 3 and its result
// is then written into the result queue, whose head drives the response.
// Throughput: one beat per cycle while no beat is held. A beat is held while an
// earlier beat still in the pipeline rewrites the same delay store word
// (a short delay with few echo channels in a frame), while the delay store
// is swept, and while the result queue has no room for it.
// Reset: registers return to their defaults, then the delay store is swept
// to zero word by word over all DELAY_FRAMES_MAX * DELAY_CHANNELS words
// (32768 at the defaults), during which no request is accepted.
// Receiver stall: up to 8 results queue behind the response channel; request
// ready drops once queued plus in-flight results reach 8.
`timescale 1ns / 1ps
module gain_and_feedback_delay #(
   parameter int DELAY_FRAMES_MAX = gfd_pkg::DELAY_FRAMES_MAX_DEF,
   parameter int DELAY_CHANNELS   = gfd_pkg::DELAY_CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   gfd_req_if.sink                        req_bus,
   gfd_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gfd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gfd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   gfd_pkg::cfg_type               cfg;
   logic                           length_written;
   logic                           push;
   gfd_pkg::rsp_item_type          push_item;
   gfd_pkg::rsp_item_type          head;
   gfd_pkg::pipe_status_type       status;
   logic [gfd_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic                           ready;

   gfd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .cfg            (cfg),
      .length_written (length_written)
   );

   gfd_pipe #(
      .DELAY_FRAMES_MAX (DELAY_FRAMES_MAX),
      .DELAY_CHANNELS   (DELAY_CHANNELS)
   ) u_pipe (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .length_written   (length_written),
      .req_valid        (req_bus.valid),
      .req_sample_in    (req_bus.sample_in),
      .req_channel      (req_bus.channel),
      .req_end_of_frame (req_bus.end_of_frame),
      .req_ready        (ready),
      .fifo_count       (fifo_count),
      .push             (push),
      .push_item        (push_item),
      .status           (status)
   );

   gfd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (rsp_bus.ready),
      .valid     (rsp_bus.valid),
      .head      (head),
      .count     (fifo_count)
   );

   assign req_bus.ready            = ready;
   assign rsp_bus.sample_out       = head.sample;
   assign rsp_bus.end_of_frame_out = head.eof;

   // No beat enters while the store is being swept
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req_bus.ready)
      else $error("request accepted during store clearing");

   // Queued plus in-flight results never exceed the queue
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fifo_count} + (gfd_pkg::FIFO_CNT_W + 1)'(status.in_flight))
         <= (gfd_pkg::FIFO_CNT_W + 1)'(gfd_pkg::FIFO_DEPTH))
      else $error("result credit exceeded");

   // A result leaving the pipeline always finds room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> fifo_count < gfd_pkg::FIFO_CNT_W'(gfd_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // An accepted beat reaches the end of the pipeline and is pushed
   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> ##3 push)
      else $error("accepted beat lost in pipeline");

endmodule
